// ===== sv/spd_pkg.sv =====
package spd_pkg;

	// Packet and chunk geometry
	localparam int MAX_PAYLOAD = 1024;
	localparam int CHUNK_BYTES = 64;
	localparam int SIZE_W = 11;
	localparam int POS_W = 7;

	localparam logic [15:0] MAX_SIZE = 16'(MAX_PAYLOAD + 2);
	localparam logic [POS_W-1:0] CHUNK_LAST_POS = POS_W'(CHUNK_BYTES + 1);
	localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(2);
	localparam logic [POS_W-1:0] CRC_HI_POS = POS_W'(3);
	localparam logic [SIZE_W-1:0] CRC_BYTES = SIZE_W'(2);

	localparam logic [7:0] REPLY_GET_PACKET = 8'h02;
	localparam logic [15:0] CRC_POLY = 16'h1189;

	// Verdict codes
	localparam logic [1:0] VERDICT_OK = 2'd0;
	localparam logic [1:0] VERDICT_WRONG_REPLY = 2'd1;
	localparam logic [1:0] VERDICT_TOO_SHORT = 2'd2;
	localparam logic [1:0] VERDICT_CRC_BAD = 2'd3;

	// Item command codes
	localparam logic CMD_STATUS = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	typedef enum logic [1:0] {
		PHASE_IDLE = 2'd0,
		PHASE_RECV = 2'd1
	} phase_t;

	typedef struct packed {
		logic byte_valid;
		logic [7:0] payload_byte;
		logic last;
		logic [1:0] verdict;
		logic signed [7:0] signal_strength;
		logic [SIZE_W-1:0] payload_length;
	} result_t;

	// One byte of CRC-16, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== sv/spd_core.sv =====
module spd_core import spd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic cmd,
	input  logic [31:0] status_word,
	input  logic [7:0] rx_byte,
	output logic res_fire,
	output result_t res
);

	phase_t phase_q, phase_n;
	logic [SIZE_W-1:0] packet_size_q, packet_size_n;
	logic [SIZE_W-1:0] bytes_left_q, bytes_left_n;
	logic [POS_W-1:0] chunk_pos_q, chunk_pos_n;
	logic first_chunk_q, first_chunk_n;
	logic [SIZE_W-1:0] emitted_q, emitted_n;
	logic [15:0] rx_crc_q, rx_crc_n;
	logic [15:0] run_crc_q, run_crc_n;
	logic [7:0] rssi_q, rssi_n;

	logic [15:0] crc_upd;
	logic [SIZE_W-1:0] size_clamped;

	assign crc_upd = crc16_byte(run_crc_q, rx_byte);
	assign size_clamped = (status_word[15:0] > MAX_SIZE) ? MAX_SIZE[SIZE_W-1:0]
		: status_word[SIZE_W-1:0];

	// Work out the next state and the result for one transaction
	always_comb begin
		phase_n = phase_q;
		packet_size_n = packet_size_q;
		bytes_left_n = bytes_left_q;
		chunk_pos_n = chunk_pos_q;
		first_chunk_n = first_chunk_q;
		emitted_n = emitted_q;
		rx_crc_n = rx_crc_q;
		run_crc_n = run_crc_q;
		rssi_n = rssi_q;
		res_fire = 1'b0;
		res = '0;
		if (en) begin
			if (cmd == CMD_STATUS) begin
				// Open a new packet, abandoning any in progress
				phase_n = PHASE_IDLE;
				chunk_pos_n = '0;
				first_chunk_n = 1'b1;
				emitted_n = '0;
				rx_crc_n = '0;
				run_crc_n = '0;
				bytes_left_n = '0;
				if (status_word[31:24] != REPLY_GET_PACKET) begin
					rssi_n = '0;
					packet_size_n = '0;
					res_fire = 1'b1;
					res.last = 1'b1;
					res.verdict = VERDICT_WRONG_REPLY;
				end else begin
					rssi_n = status_word[23:16];
					packet_size_n = size_clamped;
					if (size_clamped < CRC_BYTES) begin
						res_fire = 1'b1;
						res.last = 1'b1;
						res.verdict = VERDICT_TOO_SHORT;
						res.signal_strength = status_word[23:16];
					end else begin
						bytes_left_n = size_clamped;
						phase_n = PHASE_RECV;
					end
				end
			end else if (phase_q == PHASE_RECV) begin
				// Skip echo bytes, capture CRC, count and emit data bytes
				if (chunk_pos_q >= CRC_LO_POS) begin
					if (first_chunk_q && chunk_pos_q == CRC_LO_POS) begin
						rx_crc_n[7:0] = rx_crc_q[7:0] | rx_byte;
					end else if (first_chunk_q && chunk_pos_q == CRC_HI_POS) begin
						rx_crc_n[15:8] = rx_crc_q[15:8] | rx_byte;
					end else if (bytes_left_q != '0) begin
						bytes_left_n = bytes_left_q - SIZE_W'(1);
						if (emitted_q < packet_size_q - CRC_BYTES) begin
							emitted_n = emitted_q + SIZE_W'(1);
							run_crc_n = crc_upd;
							res_fire = 1'b1;
							res.byte_valid = 1'b1;
							res.payload_byte = rx_byte;
							res.signal_strength = rssi_q;
						end
					end
				end
				// Advance the chunk position; close the packet at chunk end
				if (chunk_pos_q >= CHUNK_LAST_POS) begin
					chunk_pos_n = '0;
					first_chunk_n = 1'b0;
					if (bytes_left_n == '0) begin
						res_fire = 1'b1;
						res = '0;
						res.last = 1'b1;
						res.signal_strength = rssi_q;
						if (rx_crc_n == run_crc_n) begin
							res.verdict = VERDICT_OK;
							res.payload_length = packet_size_q - CRC_BYTES;
						end else begin
							res.verdict = VERDICT_CRC_BAD;
						end
						phase_n = PHASE_IDLE;
					end
				end else begin
					chunk_pos_n = chunk_pos_q + POS_W'(1);
				end
			end
		end
	end

	// Hold deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			packet_size_q <= '0;
			bytes_left_q <= '0;
			chunk_pos_q <= '0;
			first_chunk_q <= 1'b1;
			emitted_q <= '0;
			rx_crc_q <= '0;
			run_crc_q <= '0;
			rssi_q <= '0;
		end else begin
			phase_q <= phase_n;
			packet_size_q <= packet_size_n;
			bytes_left_q <= bytes_left_n;
			chunk_pos_q <= chunk_pos_n;
			first_chunk_q <= first_chunk_n;
			emitted_q <= emitted_n;
			rx_crc_q <= rx_crc_n;
			run_crc_q <= run_crc_n;
			rssi_q <= rssi_n;
		end
	end

endmodule

// ===== sv/spi_packet_deframer_crc16_unit.sv =====
// Packet deframer with CRC-16 check for SPI chunk streams.
// Input channel (in_valid/in_ready): cmd = 0 carries a status word that
// opens a packet; cmd = 1 carries one byte of a 66-byte SPI chunk. The
// first two bytes of each chunk are echo bytes; bytes 2..3 of the first
// chunk hold the packet CRC, low byte first.
// Output channel (out_valid/out_ready): one transaction per payload byte
// (byte_valid = 1), and one closing transaction per packet (last = 1) with
// the verdict, rssi and payload length. Wrong reply codes and short sizes
// close at once, on the status word itself.
// A result passes through the input register, then the result register.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the state update with a byte-wide CRC step.
// Reset clears the input and result registers and returns the deframer to
// idle. When the receiver stalls, the result register holds its
// transaction, and the input register fills and then drops in_ready.
module spi_packet_deframer_crc16_unit import spd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic [31:0] status_word,
	input  logic [7:0] rx_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic byte_valid,
	output logic [7:0] payload_byte,
	output logic last,
	output logic [1:0] verdict,
	output logic signed [7:0] signal_strength,
	output logic [SIZE_W-1:0] payload_length
);

	logic valid_s1;
	logic cmd_s1;
	logic [31:0] status_word_s1;
	logic [7:0] rx_byte_s1;
	logic advance;
	logic res_fire;
	result_t res;
	result_t res_q;
	logic out_valid_q;

	// Stage 1 moves on whenever the result register can take a transaction
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd;
			status_word_s1 <= status_word;
			rx_byte_s1 <= rx_byte;
		end
	end

	spd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (valid_s1 && advance),
		.cmd         (cmd_s1),
		.status_word (status_word_s1),
		.rx_byte     (rx_byte_s1),
		.res_fire    (res_fire),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_valid = res_q.byte_valid;
	assign payload_byte = res_q.payload_byte;
	assign last = res_q.last;
	assign verdict = res_q.verdict;
	assign signal_strength = res_q.signal_strength;
	assign payload_length = res_q.payload_length;

endmodule
